/* rtl/frts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frts_pkg
// Shared types, widths and constants for the feed rate timer setup block.
// ----------------------------------------------------------------------------
package frts_pkg;

  // default build values
  localparam int FRTS_CLOCK_HZ  = 16000000;
  localparam int FRTS_TIMER_TOP = 65536;

  // field widths
  localparam int DX_W    = 21;
  localparam int FEED_W  = 16;
  localparam int SPM_W   = 10;
  localparam int CNT_W   = 22;
  localparam int CMP_W   = 16;
  localparam int SEL_W   = 3;
  localparam int P_W     = DX_W + SPM_W;      // |d| * steps_per_mm
  localparam int FP_W    = FEED_W + SPM_W;    // feed * pulses_per_mm
  localparam int MUL_W   = DX_W + FEED_W;     // shared multiplier product
  localparam int RND_SH  = 8;                 // distances are in 1/256 mm

  // stream packing
  localparam int IN_FIELDS_W  = 2 * DX_W + FEED_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_PAD_W     = IN_TDATA_W - IN_FIELDS_W;
  localparam int OUT_FIELDS_W = SEL_W + CMP_W + 3 * CNT_W + 5;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_SPM_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SPM_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PPM   = 2'd2;

  localparam logic [SPM_W-1:0] SPM_X_RST = 10'd200;
  localparam logic [SPM_W-1:0] SPM_Y_RST = 10'd200;
  localparam logic [SPM_W-1:0] PPM_RST   = 10'd400;

  // prescalers 1, 8, 64, 256, 1024 as shift amounts
  localparam int NUM_PRESC = 5;
  localparam logic [3:0] PRESC_SHIFT [NUM_PRESC] = '{4'd0, 4'd3, 4'd6, 4'd8, 4'd10};
  localparam logic [SEL_W-1:0] SEL_MAX = 3'd4;

  typedef enum logic [1:0] {
    MUL_X,
    MUL_Y,
    MUL_F
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_start;
    logic     div_cmp;     // 0: step ratio, 1: timer quotient
    logic     cap_ratio;
    logic     cap_q;
    logic     load_out;
  } frts_cmd_t;

  typedef struct packed {
    logic short_zero;
    logic cmp_skip;
    logic div_busy;
  } frts_sts_t;

endpackage

/* rtl/feed_rate_timer_setup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feed_rate_timer_setup
// Stepper timer setup for one straight move: step counts, long axis, step
// ratio, prescaler and compare value.
//
//   group   dir   handshake            payload
//   in_     in    in_tvalid/in_tready  dx_mm, dy_mm, feed_mm_per_min
//   out_    out   out_tvalid/tready    prescaler, compare, counts, flags
//   cfg_    in    cfg_we               cfg_index, cfg_wdata
//
// A move is taken only while the sequencer is idle; three multiplies, the ratio
// division and the timer division run before its result is loaded. DVD_W is
// the wider of CNT_W and the bit width of CLOCK_HZ*30: both divisions run one
// bit per cycle on a single shared divider. A zero short count skips the ratio
// division, a zero feed or zero pulses per mm skips the timer division.
// Reset is synchronous, active low, and clears the sequencer and out_tvalid.
// A held result stalls only the hand-over of the next one; the next
// transaction is taken while a result waits on the output.
// ----------------------------------------------------------------------------
module feed_rate_timer_setup
  import frts_pkg::*;
#(
  parameter int CLOCK_HZ  = FRTS_CLOCK_HZ,
  parameter int TIMER_TOP = FRTS_TIMER_TOP
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [REG_IDX_W-1:0]   cfg_index,
  input  logic [SPM_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // dx_mm[20:0], dy_mm[41:21], feed_mm_per_min[57:42], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // clock_select[2:0], compare_value[18:3], long_count[40:19],
  // short_count[62:41], long_is_x[63], dir_x[64], dir_y[65],
  // step_ratio[87:66], ratio_invalid[88], feed_invalid[89], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  frts_cmd_t cmd;
  frts_sts_t sts;

  frts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  frts_dp #(
    .CLOCK_HZ  (CLOCK_HZ),
    .TIMER_TOP (TIMER_TOP)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

/* rtl/frts_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frts_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frts_div #(
  parameter int DVD_W = 29,
  parameter int DVS_W = 26
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DVD_W + 1);

  logic                busy_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [DVS_W-1:0]    rem_r;
  logic [DVS_W-1:0]    dvs_r;
  logic [DVD_W-1:0]    quo_r;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_BITS'(DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // remainder stays below the divisor, so the difference fits DVS_W bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

/* rtl/frts_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frts_ctrl
// Sequencer: multiplies, up to two divisions on the shared divider, result load.
// ----------------------------------------------------------------------------
module frts_ctrl
  import frts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  frts_sts_t sts,
  output frts_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_X,
    S_MUL_Y,
    S_MUL_F,
    S_RATIO,
    S_RATIO_WAIT,
    S_CMP,
    S_CMP_WAIT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MUL_X;
    state_nxt     = state_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL_X;
        end
      end
      S_MUL_X: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_X;
        state_nxt   = S_MUL_Y;
      end
      S_MUL_Y: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Y;
        state_nxt   = S_MUL_F;
      end
      S_MUL_F: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_F;
        state_nxt   = S_RATIO;
      end
      S_RATIO: begin
        // no division when the short axis has no steps
        if (sts.short_zero) begin
          state_nxt = S_CMP;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_RATIO_WAIT;
        end
      end
      S_RATIO_WAIT: begin
        if (!sts.div_busy) begin
          cmd.cap_ratio = 1'b1;
          state_nxt     = S_CMP;
        end
      end
      S_CMP: begin
        cmd.div_cmp = 1'b1;
        if (sts.cmp_skip) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_CMP_WAIT;
        end
      end
      S_CMP_WAIT: begin
        if (!sts.div_busy) begin
          cmd.cap_q = 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

/* rtl/frts_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frts_dp
// Datapath: config registers, shared multiplier, step counts, divider,
// prescaler choice and the result register.
// ----------------------------------------------------------------------------
module frts_dp
  import frts_pkg::*;
#(
  parameter int CLOCK_HZ  = FRTS_CLOCK_HZ,
  parameter int TIMER_TOP = FRTS_TIMER_TOP
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [REG_IDX_W-1:0]   cfg_index,
  input  logic [SPM_W-1:0]       cfg_wdata,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  frts_cmd_t              cmd,
  output frts_sts_t              sts,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam longint unsigned NUM = 64'(CLOCK_HZ) * 64'd30;
  localparam int NUM_W = $clog2(NUM + 1);
  localparam int DVD_W = (NUM_W > CNT_W) ? NUM_W : CNT_W;
  localparam logic [DVD_W-1:0] TOP_Q = DVD_W'(TIMER_TOP);
  localparam logic [DVD_W-1:0] Q_MIN = DVD_W'(3);    // compare above one
  localparam logic [DVD_W-1:0] Q_ONE = DVD_W'(1);
  localparam logic [CMP_W-1:0] CMP_MAX = CMP_W'(TIMER_TOP - 1);
  localparam logic [CMP_W-1:0] CMP_MIN = CMP_W'(1);

  logic [SPM_W-1:0]  spm_x_r, spm_y_r, ppm_r;
  logic [DX_W-1:0]   dx_r, dy_r;
  logic [FEED_W-1:0] feed_r;
  logic [P_W-1:0]    px_r, py_r;
  logic [FP_W-1:0]   fp_r;
  logic [CNT_W-1:0]  ratio_r;
  logic [DVD_W-1:0]  q_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spm_x_r <= SPM_X_RST;
      spm_y_r <= SPM_Y_RST;
      ppm_r   <= PPM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPM_X: spm_x_r <= cfg_wdata;
        REG_SPM_Y: spm_y_r <= cfg_wdata;
        REG_PPM:   ppm_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dx_r   <= in_tdata[DX_W-1:0];
      dy_r   <= in_tdata[2*DX_W-1:DX_W];
      feed_r <= in_tdata[IN_FIELDS_W-1:2*DX_W];
    end
  end

  // shared multiplier
  logic [DX_W-1:0]   mag_x, mag_y, mul_a;
  logic [FEED_W-1:0] mul_b;
  logic [MUL_W-1:0]  prod;

  assign mag_x = dx_r[DX_W-1] ? (~dx_r + 1'b1) : dx_r;
  assign mag_y = dy_r[DX_W-1] ? (~dy_r + 1'b1) : dy_r;

  always_comb begin
    case (cmd.mul_sel)
      MUL_X: begin
        mul_a = mag_x;
        mul_b = FEED_W'(spm_x_r);
      end
      MUL_Y: begin
        mul_a = mag_y;
        mul_b = FEED_W'(spm_y_r);
      end
      MUL_F: begin
        mul_a = DX_W'(ppm_r);
        mul_b = feed_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = MUL_W'(mul_a) * MUL_W'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_X:   px_r <= prod[P_W-1:0];
        MUL_Y:   py_r <= prod[P_W-1:0];
        MUL_F:   fp_r <= prod[FP_W-1:0];
        default: ;
      endcase
    end
  end

  // round half up; products stay below 2^30 so the add cannot carry out
  logic [P_W-1:0]   px_rnd, py_rnd;
  logic [CNT_W-1:0] sx, sy, lc, sc;
  logic             lx;

  assign px_rnd = px_r + P_W'(1 << (RND_SH - 1));
  assign py_rnd = py_r + P_W'(1 << (RND_SH - 1));
  assign sx     = px_rnd[CNT_W+RND_SH-1:RND_SH];
  assign sy     = py_rnd[CNT_W+RND_SH-1:RND_SH];
  assign lx     = px_r >= py_r;
  assign lc     = lx ? sx : sy;
  assign sc     = lx ? sy : sx;

  // divider: step ratio, then CLOCK_HZ*30 / (feed*ppm)
  logic             div_busy;
  logic [DVD_W-1:0] div_q;
  logic [DVD_W-1:0] div_dvd;
  logic [FP_W-1:0]  div_dvs;

  assign div_dvd = cmd.div_cmp ? DVD_W'(NUM) : DVD_W'(lc);
  assign div_dvs = cmd.div_cmp ? fp_r : FP_W'(sc);

  frts_div #(
    .DVD_W (DVD_W),
    .DVS_W (FP_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_ratio) begin
      ratio_r <= div_q[CNT_W-1:0];
    end
    if (cmd.cap_q) begin
      q_r <= div_q;
    end
  end

  // floor(floor(a/b)/p) == floor(a/(b*p)), so each prescaler is a shift
  logic [SEL_W-1:0] sel;
  logic [CMP_W-1:0] cmp;
  logic [DVD_W-1:0] q_pick, q_i;
  logic             found;
  logic             cmp_skip;
  logic             finv, rinv;
  logic [CNT_W-1:0] ratio_o;

  assign cmp_skip = (feed_r == '0) || (ppm_r == '0);
  assign finv     = (feed_r == '0);
  assign rinv     = (sc == '0);
  assign ratio_o  = rinv ? '1 : ratio_r;

  always_comb begin
    sel    = SEL_MAX;
    q_pick = q_r >> PRESC_SHIFT[NUM_PRESC-1];
    found  = 1'b0;
    q_i    = '0;
    for (int i = 0; i < NUM_PRESC; i++) begin
      q_i = q_r >> PRESC_SHIFT[i];
      if (!found && q_i >= Q_MIN && q_i <= TOP_Q) begin
        found  = 1'b1;
        sel    = SEL_W'(i);
        q_pick = q_i;
      end
    end
    if (cmp_skip) begin
      sel = SEL_MAX;
      cmp = CMP_MAX;
    end else if (q_pick <= Q_ONE) begin
      cmp = CMP_MIN;
    end else if (q_pick - Q_ONE >= TOP_Q) begin
      cmp = CMP_MAX;
    end else begin
      cmp = CMP_W'(q_pick - Q_ONE);
    end
  end

  assign out_data_nxt = {{OUT_PAD_W{1'b0}}, finv, rinv, ratio_o, dy_r[DX_W-1],
                         dx_r[DX_W-1], lx, sc, lc, cmp, sel};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign sts.short_zero = rinv;
  assign sts.cmp_skip   = cmp_skip;
  assign sts.div_busy   = div_busy;
  assign out_tdata      = out_data_r;

endmodule

/* rtl/frts_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frts_chk
// Port-level checks on the result stream of feed_rate_timer_setup.
// ----------------------------------------------------------------------------
module frts_chk
  import frts_pkg::*;
#(
  parameter int TIMER_TOP = FRTS_TIMER_TOP
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= SEL_MAX)
    else $error("prescaler select out of range");

  a_ratio_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[88] == (out_tdata[62:41] == '0))
    else $error("ratio flag disagrees with short count");

  a_long_ge_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[40:19] >= out_tdata[62:41])
    else $error("long count below short count");

  a_feed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[89] |->
      out_tdata[2:0] == SEL_MAX && out_tdata[18:3] == CMP_W'(TIMER_TOP - 1))
    else $error("zero feed not forced to slowest timer");

endmodule

bind feed_rate_timer_setup frts_chk #(
  .TIMER_TOP (TIMER_TOP)
) u_frts_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* test/frts_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frts_checker
// Watches the move and result streams and the register port of the feed rate
// timer setup block. It works out the timer setup of every accepted move from
// its own copy of the registers and compares each accepted result with the
// oldest setup still waiting.
// ----------------------------------------------------------------------------
module frts_checker
  import frts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [REG_IDX_W-1:0]   cfg_index,
  input  logic [SPM_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // dx_mm, dy_mm, feed_mm_per_min, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // clock_select, compare_value, long_count, short_count, long_is_x, dir_x,
  // dir_y, step_ratio, ratio_invalid, feed_invalid, zero pad
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     mismatches,
  output int                     outstanding
);

  // highest field first, so the struct lines up with the low bits of out_tdata
  typedef struct packed {
    logic             feed_invalid;
    logic             ratio_invalid;
    logic [CNT_W-1:0] step_ratio;
    logic             dir_y;
    logic             dir_x;
    logic             long_is_x;
    logic [CNT_W-1:0] short_count;
    logic [CNT_W-1:0] long_count;
    logic [CMP_W-1:0] compare_value;
    logic [SEL_W-1:0] clock_select;
  } timer_setup_t;

  localparam int SETUP_W = $bits(timer_setup_t);
  localparam longint unsigned TICKS_30S = 64'(FRTS_CLOCK_HZ) * 64'd30;
  localparam longint unsigned TOP       = 64'(FRTS_TIMER_TOP);

  logic [SPM_W-1:0] spm_x;
  logic [SPM_W-1:0] spm_y;
  logic [SPM_W-1:0] ppm;

  timer_setup_t setup_q [$];

  function automatic longint unsigned magnitude(logic [DX_W-1:0] d);
    return d[DX_W-1] ? ((64'd1 << DX_W) - 64'(d)) : 64'(d);
  endfunction

  function automatic timer_setup_t predict_setup(logic [DX_W-1:0] dx, logic [DX_W-1:0] dy,
                                                 logic [FEED_W-1:0] feed);
    timer_setup_t     r;
    longint unsigned  px, py, sx, sy, lc, sc, ratio, den, q, cmp;
    logic [SEL_W-1:0] sel;
    bit               found;
    px = magnitude(dx) * 64'(spm_x);
    py = magnitude(dy) * 64'(spm_y);
    sx = (px + 64'd128) >> RND_SH;
    sy = (py + 64'd128) >> RND_SH;
    r.long_is_x = (px >= py);
    lc = r.long_is_x ? sx : sy;
    sc = r.long_is_x ? sy : sx;
    r.long_count    = lc[CNT_W-1:0];
    r.short_count   = sc[CNT_W-1:0];
    r.dir_x         = dx[DX_W-1];
    r.dir_y         = dy[DX_W-1];
    r.ratio_invalid = (sc == 0);
    ratio = (sc == 0) ? {CNT_W{1'b1}} : lc / sc;
    r.step_ratio    = ratio[CNT_W-1:0];
    r.feed_invalid  = (feed == 0);

    sel   = SEL_MAX;
    cmp   = TOP - 1;
    found = 1'b0;
    q     = 0;
    if (feed != 0 && ppm != 0) begin
      for (int i = 0; i < NUM_PRESC; i++) begin
        if (!found) begin
          den = (64'(feed) * 64'(ppm)) << PRESC_SHIFT[i];
          q   = TICKS_30S / den;
          // compare = q - 1 has to sit strictly between 1 and the top
          if (q >= 3 && q <= TOP) begin
            found = 1'b1;
            sel   = i[SEL_W-1:0];
          end
        end
      end
      // nothing fitted: q is left at the /1024 quotient
      if (q <= 1)
        cmp = 1;
      else if (q - 1 >= TOP)
        cmp = TOP - 1;
      else
        cmp = q - 1;
    end
    r.clock_select  = sel;
    r.compare_value = cmp[CMP_W-1:0];
    return r;
  endfunction

  function automatic string fmt_setup(timer_setup_t s);
    return {$sformatf("sel=%0d cmp=%0d long=%0d short=%0d lx=%0b",
                      s.clock_select, s.compare_value, s.long_count, s.short_count,
                      s.long_is_x),
            $sformatf(" dirx=%0b diry=%0b ratio=%0d rinv=%0b finv=%0b",
                      s.dir_x, s.dir_y, s.step_ratio, s.ratio_invalid, s.feed_invalid)};
  endfunction

  always @(posedge clk) begin : watch
    timer_setup_t got;
    timer_setup_t want;
    if (!rst_n) begin
      spm_x       = SPM_X_RST;
      spm_y       = SPM_Y_RST;
      ppm         = PPM_RST;
      mismatches  = 0;
      outstanding = 0;
      setup_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SPM_X: spm_x = cfg_wdata;
          REG_SPM_Y: spm_y = cfg_wdata;
          REG_PPM:   ppm   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        setup_q.push_back(predict_setup(in_tdata[DX_W-1:0], in_tdata[2*DX_W-1:DX_W],
                                        in_tdata[2*DX_W+FEED_W-1:2*DX_W]));
        outstanding++;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[SETUP_W-1:0];
        if (setup_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: %s", fmt_setup(got));
        end else begin
          want = setup_q.pop_front();
          outstanding--;
          if (want != got) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch");
              $display("  expected %s", fmt_setup(want));
              $display("  actual   %s", fmt_setup(got));
            end
          end
        end
      end
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives moves and register writes into the feed rate timer setup block with
// random gaps and output stalls; a checker beside the block predicts and
// compares every result. Directed corner moves come first, then random moves
// over several register settings.
// ----------------------------------------------------------------------------
module tb;
  import frts_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_NONE = 2'd3;   // no register behind it

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [REG_IDX_W-1:0]   cfg_index  = '0;
  logic [SPM_W-1:0]       cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int pending;
  bit no_idle = 1'b0;

  feed_rate_timer_setup u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  frts_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (fail_count),
    .outstanding (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic int draw_gap();
    if (no_idle || $urandom_range(0, 3) == 0)
      return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [DX_W-1:0] rand_dist();
    int v;
    v = $urandom_range(1, 4096);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? 21'h0FFFFF : 21'h100000;
      2, 3:    return DX_W'($urandom);
      default: return $urandom_range(0, 1) ? DX_W'(-v) : DX_W'(v);
    endcase
  endfunction

  function automatic logic [FEED_W-1:0] rand_feed();
    case ($urandom_range(0, 15))
      0:             return '0;
      1, 2, 3:       return FEED_W'($urandom_range(1, 30));
      4, 5, 6, 7, 8: return FEED_W'($urandom_range(31, 2000));
      default:       return FEED_W'($urandom);
    endcase
  endfunction

  function automatic logic [SPM_W-1:0] rand_reg();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 10'd1023;
      2:       return SPM_W'($urandom);
      default: return SPM_W'($urandom_range(1, 1023));
    endcase
  endfunction

  // returns at the edge that took the move; in_tvalid is left high
  task automatic send_move(input logic [DX_W-1:0] dx, input logic [DX_W-1:0] dy,
                           input logic [FEED_W-1:0] feed);
    int g;
    g = draw_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{IN_PAD_W{1'b0}}, feed, dy, dx};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // block must be idle; write enable stays high across the burst
  task automatic write_regs(input logic [SPM_W-1:0] x, input logic [SPM_W-1:0] y,
                            input logic [SPM_W-1:0] p, input bit stray);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SPM_X;
    cfg_wdata <= x;
    @(posedge clk);
    cfg_index <= REG_SPM_Y;
    cfg_wdata <= y;
    @(posedge clk);
    cfg_index <= REG_PPM;
    cfg_wdata <= p;
    @(posedge clk);
    if (stray) begin
      cfg_index <= REG_NONE;
      cfg_wdata <= SPM_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // result side: gap after each transaction, or a stall once a result shows
  initial begin : sink
    int g;
    while (!rst_n) @(posedge clk);
    forever begin
      g = draw_gap();
      if (g > 0) begin
        out_tready <= 1'b0;
        if ($urandom_range(0, 1)) begin
          @(negedge clk);
          while (!out_tvalid) @(negedge clk);
          @(posedge clk);
        end
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(negedge clk);
      while (!out_tvalid) @(negedge clk);
      @(posedge clk);
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: extremes, ties, zero counts, each reachable prescaler
    send_move(21'd0, 21'd0, 16'd0);
    send_move(21'h0FFFFF, 21'h0FFFFF, 16'd65535);
    send_move(21'h100000, 21'h100000, 16'd1);
    send_move(21'h100000, 21'h0FFFFF, 16'd10);
    send_move(21'd256, 21'd256, 16'd100);
    send_move(21'd100, 21'd2000, 16'd100);
    send_move(-21'sd2560, 21'd256, 16'd600);
    send_move(21'd16, 21'd16, 16'd50);       // rounding exactly on the half
    send_move(21'd1000, 21'd0, 16'd100);
    send_move(21'd0, -21'sd1000, 16'd100);
    send_move(21'd5000, 21'd1234, 16'd18);
    send_move(21'd5000, 21'd1234, 16'd19);
    send_move(21'd7, 21'd3, 16'd0);
    send_move(-21'sd1, 21'd1, 16'd30000);

    wait_drained();
    write_regs(10'd1023, 10'd1, 10'd1023, 1'b0);
    send_move(21'h0FFFFF, 21'h0FFFFF, 16'd1);
    send_move(21'd1, 21'd1, 16'd7);          // short axis rounds down to nothing
    send_move(-21'sd300, 21'd127, 16'd65535);
    send_move(21'd0, 21'd128, 16'd469);

    wait_drained();
    write_regs(10'd1, 10'd1023, 10'd1, 1'b0);
    send_move(21'h0FFFFF, 21'h100000, 16'd1); // no prescaler fits
    send_move(21'd128, 21'd5, 16'd30);
    send_move(-21'sd5, 21'd500, 16'd10);
    send_move(21'd2, 21'd2, 16'd65535);

    // zero steps and zero pulses per mm, plus a write to no register
    wait_drained();
    write_regs(10'd0, 10'd0, 10'd0, 1'b1);
    send_move(21'd1000, -21'sd1000, 16'd100);
    send_move(21'h100000, 21'h0FFFFF, 16'd0);
    send_move(21'd1, 21'd1, 16'd65535);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0:       write_regs(10'd1023, 10'd1023, 10'd1023, 1'b0);
        1:       write_regs(10'd1, 10'd1, 10'd1, 1'b1);
        default: write_regs(rand_reg(), rand_reg(), rand_reg(),
                            1'($urandom_range(0, 1)));
      endcase
      no_idle = (ph == 3);
      repeat (90) send_move(rand_dist(), rand_dist(), rand_feed());
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
